### hw/rtl/gf2m_pkg.sv
// gf2m_pkg: shared types and constants of the GF(2^m) arithmetic unit.
// Item structs, operation and status codes, sequencer states and step-unit control.
// No dependencies.
package gf2m_pkg;

	localparam int FIELD_BITS_DEF = 128;
	localparam int WORD_BITS      = 64;

	// operation codes carried in the kind field
	localparam logic [1:0] KIND_ADD = 2'd0;
	localparam logic [1:0] KIND_MUL = 2'd1;
	localparam logic [1:0] KIND_INV = 2'd2;
	localparam logic [1:0] KIND_DIV = 2'd3;

	// status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_NO_POLY  = 2'd1;
	localparam logic [1:0] STAT_INV_ZERO = 2'd2;

	// configuration register indexes
	localparam logic REG_POLY_LOW  = 1'b0;
	localparam logic REG_POLY_HIGH = 1'b1;

	typedef struct packed {
		logic [1:0]           kind;
		logic [WORD_BITS-1:0] a_low;
		logic [WORD_BITS-1:0] a_high;
		logic [WORD_BITS-1:0] b_low;
		logic [WORD_BITS-1:0] b_high;
	} in_item_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] res_low;
		logic [WORD_BITS-1:0] res_high;
		logic [1:0]           status;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DEG_A,
		ST_DEG_B,
		ST_DISP,
		ST_INV,
		ST_MUL,
		ST_FIN
	} state_t;

	typedef enum logic {
		MODE_MUL,
		MODE_INV
	} step_mode_t;

	typedef struct packed {
		step_mode_t mode;
		logic       has_m;
	} step_ctl_t;

endpackage

### hw/rtl/gf2m_deg.sv
// gf2m_deg: two-stage registered degree finder for the reduction polynomial.
// Stage 1 encodes each byte, stage 2 picks the highest non-empty byte.
// Depends on gf2m_pkg (none of its items needed beyond the parameter defaults).
module gf2m_deg #(
	parameter int W  = gf2m_pkg::FIELD_BITS_DEF,
	parameter int MW = $clog2(gf2m_pkg::FIELD_BITS_DEF)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [W-1:0]  poly,
	output logic [MW-1:0] m,
	output logic          has_m
);

	localparam int G  = (W + 7) / 8;
	localparam int PW = $clog2(G * 8);

	logic [G*8-1:0] pad;
	logic [G-1:0]   any_d;
	logic [2:0]     idx_d [G];
	logic [G-1:0]   any_s1;
	logic [2:0]     idx_s1 [G];
	logic [PW-1:0]  m_d;
	logic [MW-1:0]  m_s2;
	logic           has_s2;

	always_comb begin
		pad = '0;
		pad[W-1:0] = poly;
		for (int g = 0; g < G; g++) begin
			any_d[g] = |pad[g*8 +: 8];
			idx_d[g] = 3'd0;
			for (int k = 0; k < 8; k++) begin
				if (pad[g*8 + k]) begin
					idx_d[g] = 3'(k);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		any_s1 <= any_d;
		for (int g = 0; g < G; g++) begin
			idx_s1[g] <= idx_d[g];
		end
	end

	// highest group wins: later iterations override
	always_comb begin
		m_d = '0;
		for (int g = 0; g < G; g++) begin
			if (any_s1[g]) begin
				m_d = PW'(g * 8 + int'(idx_s1[g]));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_s2 <= 1'b0;
		end else begin
			has_s2 <= |any_s1;
		end
	end

	always_ff @(posedge clk) begin
		m_s2 <= MW'(m_d);
	end

	assign m     = m_s2;
	assign has_m = has_s2;

endmodule

### hw/rtl/gf2m_step.sv
// gf2m_step: the shared step unit, one multiply or one inversion step per cycle.
// Multiply: v = accumulator, r = running multiple of a, s = b shifted right.
// Depends on gf2m_pkg (step_ctl_t, step_mode_t).
module gf2m_step #(
	parameter int W  = gf2m_pkg::FIELD_BITS_DEF,
	parameter int MW = $clog2(gf2m_pkg::FIELD_BITS_DEF),
	parameter int CW = $clog2(2 * gf2m_pkg::FIELD_BITS_DEF)
) (
	input  gf2m_pkg::step_ctl_t ctl,
	input  logic [MW-1:0]       m,
	input  logic [W-1:0]        poly,
	input  logic [W-1:0]        s,
	input  logic [W-1:0]        r,
	input  logic [W-1:0]        u,
	input  logic [W-1:0]        v,
	input  logic [CW-1:0]       delta,
	output logic [W-1:0]        s_n,
	output logic [W-1:0]        r_n,
	output logic [W-1:0]        u_n,
	output logic [W-1:0]        v_n,
	output logic [CW-1:0]       delta_n
);

	logic [W-1:0] c1;
	logic [W-1:0] s1;
	logic [W-1:0] v1;

	always_comb begin
		s_n     = s;
		r_n     = r;
		u_n     = u;
		v_n     = v;
		delta_n = delta;
		c1      = r << 1;
		s1      = s[m] ? (s ^ r) : s;
		v1      = s[m] ? (v ^ u) : v;
		unique case (ctl.mode)
			gf2m_pkg::MODE_MUL: begin
				v_n = s[0] ? (v ^ r) : v;
				r_n = (ctl.has_m && c1[m]) ? (c1 ^ poly) : c1;
				s_n = s >> 1;
			end
			gf2m_pkg::MODE_INV: begin
				if (!r[m]) begin
					r_n     = r << 1;
					u_n     = u << 1;
					delta_n = delta + CW'(1);
				end else if (delta == '0) begin
					// swap roles
					s_n     = r;
					r_n     = s1 << 1;
					u_n     = v1 << 1;
					v_n     = u;
					delta_n = CW'(1);
				end else begin
					s_n     = s1 << 1;
					v_n     = v1;
					u_n     = u >> 1;
					delta_n = delta - CW'(1);
				end
			end
			default: ;
		endcase
	end

endmodule

### hw/rtl/gf2m_arith_unit.sv
// gf2m_arith_unit: GF(2^m) add / multiply / invert / divide in polynomial basis.
// Sequencer, operand registers, configuration and output register.
// Depends on gf2m_pkg, gf2m_deg, gf2m_step.
//
// Usage notes:
//  - Input channel in_valid / in_stall / in_data; an item is taken when valid
//    is high and stall low. in_stall is high from the accepting edge until the
//    result has been moved into the output register.
//  - Output channel out_valid / out_stall / out_data; one result item per input.
//    The output register holds the item while out_stall is high; the next input
//    item can be taken and worked on meanwhile, and finishes once the slot frees.
//  - Config: cfg_we writes cfg_data to poly_low (index 0) or poly_high
//    (index 1). Write only while no item is in flight.
//  - Processing order, accept to out_valid (W = FIELD_BITS, m = polynomial degree):
//    ST_DEG_A and ST_DEG_B wait on the registered degree finder, ST_DISP
//    dispatches, then the loops of the step unit (one step per cycle) run: one
//    multiply step per b bit (W steps), 2m inversion steps, and an end-of-loop
//    state per loop; ST_FIN loads the output. Add and error statuses skip loops.
//  - One item at a time; the next item is taken at the earliest on the edge
//    after the result is loaded.
//  - Reset clears the polynomial to zero, idles the sequencer and empties the
//    output register.
module gf2m_arith_unit #(
	parameter int FIELD_BITS = gf2m_pkg::FIELD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  gf2m_pkg::in_item_t            in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output gf2m_pkg::out_item_t           out_data,
	input  logic                          cfg_we,
	input  logic                          cfg_idx,
	input  logic [gf2m_pkg::WORD_BITS-1:0] cfg_data
);

	localparam int W  = FIELD_BITS;
	localparam int MW = $clog2(FIELD_BITS);
	localparam int CW = $clog2(2 * FIELD_BITS);
	localparam int DW = 2 * gf2m_pkg::WORD_BITS;

	gf2m_pkg::state_t state_q, state_d;

	logic [gf2m_pkg::WORD_BITS-1:0] poly_lo_q, poly_hi_q;
	logic [DW-1:0]   poly_full;
	logic [W-1:0]    poly_w;

	logic [1:0]      kind_q;
	logic [W-1:0]    a_q, b_q;
	logic [DW-1:0]   a_full, b_full;

	logic [W-1:0]    s_q, r_q, u_q, v_q;
	logic [W-1:0]    s_d, r_d, u_d, v_d;
	logic [CW-1:0]   delta_q, delta_d;
	logic [CW-1:0]   cnt_q, cnt_d;
	logic [1:0]      stat_q, stat_d;

	logic [W-1:0]    s_n, r_n, u_n, v_n;
	logic [CW-1:0]   delta_n;
	logic [W-1:0]    x_sel;

	logic [MW-1:0]   deg_m;
	logic            deg_has;
	gf2m_pkg::step_ctl_t ctl;

	logic            take_in;
	logic            out_load;
	logic            out_valid_q;
	gf2m_pkg::out_item_t out_q;
	logic [DW-1:0]   res_full;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_lo_q <= '0;
			poly_hi_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				gf2m_pkg::REG_POLY_LOW:  poly_lo_q <= cfg_data;
				gf2m_pkg::REG_POLY_HIGH: poly_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign poly_full = {poly_hi_q, poly_lo_q};
	assign poly_w    = poly_full[W-1:0];
	assign a_full    = {in_data.a_high, in_data.a_low};
	assign b_full    = {in_data.b_high, in_data.b_low};

	gf2m_deg #(
		.W  (W),
		.MW (MW)
	) u_deg (
		.clk    (clk),
		.arst_n (arst_n),
		.poly   (poly_w),
		.m      (deg_m),
		.has_m  (deg_has)
	);

	gf2m_step #(
		.W  (W),
		.MW (MW),
		.CW (CW)
	) u_step (
		.ctl     (ctl),
		.m       (deg_m),
		.poly    (poly_w),
		.s       (s_q),
		.r       (r_q),
		.u       (u_q),
		.v       (v_q),
		.delta   (delta_q),
		.s_n     (s_n),
		.r_n     (r_n),
		.u_n     (u_n),
		.v_n     (v_n),
		.delta_n (delta_n)
	);

	assign in_stall = (state_q != gf2m_pkg::ST_IDLE);
	assign take_in  = in_valid && (state_q == gf2m_pkg::ST_IDLE);

	// operand capture
	always_ff @(posedge clk) begin
		if (take_in) begin
			kind_q <= in_data.kind;
			a_q    <= a_full[W-1:0];
			b_q    <= b_full[W-1:0];
		end
	end

	assign x_sel = (kind_q == gf2m_pkg::KIND_INV) ? a_q : b_q;

	// sequencer: next state and datapath loads
	always_comb begin
		state_d  = state_q;
		s_d      = s_q;
		r_d      = r_q;
		u_d      = u_q;
		v_d      = v_q;
		delta_d  = delta_q;
		cnt_d    = cnt_q;
		stat_d   = stat_q;
		out_load = 1'b0;
		ctl.mode  = gf2m_pkg::MODE_MUL;
		ctl.has_m = deg_has;
		unique case (state_q)
			gf2m_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = gf2m_pkg::ST_DEG_A;
				end
			end
			gf2m_pkg::ST_DEG_A: state_d = gf2m_pkg::ST_DEG_B;
			gf2m_pkg::ST_DEG_B: state_d = gf2m_pkg::ST_DISP;
			gf2m_pkg::ST_DISP: begin
				stat_d = gf2m_pkg::STAT_OK;
				v_d    = '0;
				case (kind_q)
					gf2m_pkg::KIND_ADD: begin
						v_d     = a_q ^ b_q;
						state_d = gf2m_pkg::ST_FIN;
					end
					gf2m_pkg::KIND_MUL: begin
						r_d     = a_q;
						s_d     = b_q;
						cnt_d   = CW'(W);
						state_d = gf2m_pkg::ST_MUL;
					end
					default: begin
						if (!deg_has) begin
							stat_d  = gf2m_pkg::STAT_NO_POLY;
							state_d = gf2m_pkg::ST_FIN;
						end else if (x_sel == '0) begin
							stat_d  = gf2m_pkg::STAT_INV_ZERO;
							state_d = gf2m_pkg::ST_FIN;
						end else begin
							s_d     = poly_w;
							r_d     = x_sel;
							u_d     = W'(1);
							delta_d = '0;
							cnt_d   = CW'({deg_m, 1'b0});
							state_d = gf2m_pkg::ST_INV;
						end
					end
				endcase
			end
			gf2m_pkg::ST_INV: begin
				ctl.mode = gf2m_pkg::MODE_INV;
				if (cnt_q == '0) begin
					if (kind_q == gf2m_pkg::KIND_DIV) begin
						// a times inverse
						v_d     = '0;
						r_d     = a_q;
						s_d     = u_q;
						cnt_d   = CW'(W);
						state_d = gf2m_pkg::ST_MUL;
					end else begin
						v_d     = u_q;
						state_d = gf2m_pkg::ST_FIN;
					end
				end else begin
					s_d     = s_n;
					r_d     = r_n;
					u_d     = u_n;
					v_d     = v_n;
					delta_d = delta_n;
					cnt_d   = cnt_q - CW'(1);
				end
			end
			gf2m_pkg::ST_MUL: begin
				if (cnt_q == '0) begin
					state_d = gf2m_pkg::ST_FIN;
				end else begin
					s_d   = s_n;
					r_d   = r_n;
					v_d   = v_n;
					cnt_d = cnt_q - CW'(1);
				end
			end
			gf2m_pkg::ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = gf2m_pkg::ST_IDLE;
				end
			end
			default: state_d = gf2m_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gf2m_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		s_q     <= s_d;
		r_q     <= r_d;
		u_q     <= u_d;
		v_q     <= v_d;
		delta_q <= delta_d;
		cnt_q   <= cnt_d;
		stat_q  <= stat_d;
	end

	// output register
	always_comb begin
		res_full = '0;
		res_full[W-1:0] = v_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.res_low  <= res_full[gf2m_pkg::WORD_BITS-1:0];
			out_q.res_high <= res_full[DW-1:gf2m_pkg::WORD_BITS];
			out_q.status   <= stat_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
